>>> sv/msp_pkg.sv
// ============================================================================
// msp_pkg
// Types and constants shared by the message packet segmenter modules.
// ============================================================================
`default_nettype none

package msp_pkg;

   localparam logic [15:0] HDR_BYTES      = 16'd8;
   localparam logic [15:0] MIN_PACKET     = 16'd9;
   localparam logic [15:0] SEG_SIZE_RESET = 16'd1024;

   // Register indexes of the configuration port.
   localparam logic REG_SEG_SIZE = 1'b0;

   // Position of the byte being shown on the result channel.
   typedef enum logic [3:0] {
      POS_FRAME_LO  = 4'd0,
      POS_FRAME_MID = 4'd1,
      POS_FRAME_HI  = 4'd2,
      POS_INDEX_LO  = 4'd3,
      POS_INDEX_HI  = 4'd4,
      POS_LEN_LO    = 4'd5,
      POS_LEN_MID   = 4'd6,
      POS_LEN_HI    = 4'd7,
      POS_PAYLOAD   = 4'd8
   } msp_pos_type;

   // One accepted byte together with the header it may need.
   typedef struct packed {
      logic        with_header;
      logic [21:0] frame;
      logic [1:0]  mode;
      logic [15:0] index;
      logic [23:0] length;
      logic [7:0]  data;
      logic        eop;
      logic        eom;
   } msp_item_type;

endpackage

`default_nettype wire

>>> sv/msp_req_if.sv
// ============================================================================
// msp_req_if
// Input channel: one content byte with the message attributes.
// ============================================================================
`default_nettype none

interface msp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [21:0] frame_number;
   logic [1:0]  stream_mode;
   logic [23:0] message_length;

   modport source (output valid, output data_byte, output frame_number,
                   output stream_mode, output message_length, input ready);
   modport sink   (input valid, input data_byte, input frame_number,
                   input stream_mode, input message_length, output ready);
endinterface

`default_nettype wire

>>> sv/msp_rsp_if.sv
// ============================================================================
// msp_rsp_if
// Result channel: one packet byte with end-of-packet and end-of-message.
// ============================================================================
`default_nettype none

interface msp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_packet;
   logic       end_of_message;

   modport source (output valid, output out_byte, output end_of_packet,
                   output end_of_message, input ready);
   modport sink   (input valid, input out_byte, input end_of_packet,
                   input end_of_message, output ready);
endinterface

`default_nettype wire

>>> sv/msp_csr.sv
// ============================================================================
// msp_csr
// APB-style register file holding the packet size.
// ============================================================================
`default_nettype none

module msp_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output logic      [15:0] seg_size
);
   import msp_pkg::*;

   logic [15:0] size_ff;
   logic [15:0] size_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr[2] == REG_SEG_SIZE);

   always_comb begin
      size_in = size_ff;
      if (wr_en) begin
         size_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SEG_SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_SEG_SIZE) begin
         csr_prdata = {16'd0, size_ff};
      end
   end

   assign seg_size = size_ff;
endmodule

`default_nettype wire

>>> sv/msp_core.sv
// ============================================================================
// msp_core
// Message state: latches attributes, counts payload bytes and packets.
// ============================================================================
`default_nettype none

module msp_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           seg_size,
   input  wire logic                  load_ok,
   msp_req_if.sink                    req,
   output logic                       push,
   output msp_pkg::msp_item_type      item
);
   import msp_pkg::*;

   logic [23:0] bytes_left_ff, bytes_left_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [15:0] packet_index_ff, packet_index_in;
   logic [21:0] held_frame_ff, held_frame_in;
   logic [1:0]  held_mode_ff, held_mode_in;
   logic [23:0] held_length_ff, held_length_in;

   logic        accept;
   logic        open_msg;
   logic        drop;
   logic [15:0] eff_size;
   logic [15:0] payload_max;
   logic [15:0] cur_count;
   logic [15:0] cur_index;
   logic [23:0] cur_left;
   logic [15:0] next_count;
   logic [23:0] next_left;
   logic        eom;
   logic        eop;

   assign req.ready = load_ok;
   assign accept    = req.valid && load_ok;
   assign open_msg  = (bytes_left_ff == 24'd0);
   // A first byte of a zero-length message is taken and dropped.
   assign drop      = open_msg && (req.message_length == 24'd0);

   assign eff_size    = (seg_size < MIN_PACKET) ? MIN_PACKET : seg_size;
   assign payload_max = eff_size - HDR_BYTES;

   always_comb begin
      item.frame  = open_msg ? req.frame_number   : held_frame_ff;
      item.mode   = open_msg ? req.stream_mode    : held_mode_ff;
      item.length = open_msg ? req.message_length : held_length_ff;
      cur_left    = open_msg ? req.message_length : bytes_left_ff;
      cur_count   = open_msg ? 16'd0 : payload_count_ff;
      cur_index   = open_msg ? 16'd0 : packet_index_ff;
      next_count  = cur_count + 16'd1;
      next_left   = cur_left - 24'd1;
      eom         = (next_left == 24'd0);
      eop         = eom || (next_count >= payload_max);
      item.with_header = (cur_count == 16'd0);
      item.index  = cur_index;
      item.data   = req.data_byte;
      item.eop    = eop;
      item.eom    = eom;
   end

   assign push = accept && !drop;

   always_comb begin
      bytes_left_in    = bytes_left_ff;
      payload_count_in = payload_count_ff;
      packet_index_in  = packet_index_ff;
      held_frame_in    = held_frame_ff;
      held_mode_in     = held_mode_ff;
      held_length_in   = held_length_ff;
      if (push) begin
         held_frame_in    = item.frame;
         held_mode_in     = item.mode;
         held_length_in   = item.length;
         bytes_left_in    = next_left;
         payload_count_in = eop ? 16'd0 : next_count;
         packet_index_in  = eop ? (cur_index + 16'd1) : cur_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= 24'd0;
         payload_count_ff <= 16'd0;
         packet_index_ff  <= 16'd0;
         held_frame_ff    <= 22'd0;
         held_mode_ff     <= 2'd0;
         held_length_ff   <= 24'd0;
      end else begin
         bytes_left_ff    <= bytes_left_in;
         payload_count_ff <= payload_count_in;
         packet_index_ff  <= packet_index_in;
         held_frame_ff    <= held_frame_in;
         held_mode_ff     <= held_mode_in;
         held_length_ff   <= held_length_in;
      end
   end
endmodule

`default_nettype wire

>>> sv/msp_serial.sv
// ============================================================================
// msp_serial
// Result register: sends the header bytes when the item opens a packet, then the payload byte.
// ============================================================================
`default_nettype none

module msp_serial (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire msp_pkg::msp_item_type item,
   output logic                       load_ok,
   msp_rsp_if.source                  rsp
);
   import msp_pkg::*;

   logic         valid_ff, valid_in;
   msp_pos_type  pos_ff, pos_in;
   msp_item_type item_ff, item_in;

   logic take;
   logic last;
   logic done;

   assign take    = valid_ff && rsp.ready;
   assign last    = (pos_ff == POS_PAYLOAD);
   assign done    = take && last;
   // A new item may load while the final byte of the current one leaves.
   assign load_ok = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      item_in  = item_ff;
      if (load_ok) begin
         valid_in = push;
         item_in  = item;
         pos_in   = item.with_header ? POS_FRAME_LO : POS_PAYLOAD;
      end else if (take) begin
         pos_in = msp_pos_type'(pos_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= POS_PAYLOAD;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_comb begin
      unique case (pos_ff)
         POS_FRAME_LO:  rsp.out_byte = item_ff.frame[7:0];
         POS_FRAME_MID: rsp.out_byte = item_ff.frame[15:8];
         POS_FRAME_HI:  rsp.out_byte = {item_ff.mode, item_ff.frame[21:16]};
         POS_INDEX_LO:  rsp.out_byte = item_ff.index[7:0];
         POS_INDEX_HI:  rsp.out_byte = item_ff.index[15:8];
         POS_LEN_LO:    rsp.out_byte = item_ff.length[7:0];
         POS_LEN_MID:   rsp.out_byte = item_ff.length[15:8];
         POS_LEN_HI:    rsp.out_byte = item_ff.length[23:16];
         POS_PAYLOAD:   rsp.out_byte = item_ff.data;
         default:       rsp.out_byte = item_ff.data;
      endcase
   end

   assign rsp.valid          = valid_ff;
   assign rsp.end_of_packet  = last && item_ff.eop;
   assign rsp.end_of_message = last && item_ff.eom;
endmodule

`default_nettype wire

>>> sv/message_packet_segmenter.sv
// ============================================================================
// message_packet_segmenter
// Cuts a byte stream into packets, each led by an 8-byte header.
// ============================================================================
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        data_byte, frame_number,
//                                          stream_mode, message_length
//   rsp      out        valid/ready        out_byte, end_of_packet,
//                                          end_of_message
//   csr      in         APB, pready high   segment size at byte address 0
//
// A payload byte that continues a packet is accepted every cycle while rsp
// is ready and appears on rsp in the cycle after. A byte that opens a packet
// holds req while the eight header bytes leave the result register ahead of it.
// Synchronous reset clears the message state and the packet size to 1024.
// A stall on rsp holds the result register; req is taken again as soon as
// the last byte of the held item leaves.
//
`default_nettype none

module message_packet_segmenter (
   input  wire logic        clock,
   input  wire logic        reset,
   msp_req_if.sink          req,
   msp_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import msp_pkg::*;

   logic [15:0]  seg_size;
   logic         load_ok;
   logic         push;
   msp_item_type item;

   msp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seg_size    (seg_size)
   );

   msp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .seg_size    (seg_size),
      .load_ok     (load_ok),
      .req         (req),
      .push        (push),
      .item        (item)
   );

   msp_serial u_serial (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .item    (item),
      .load_ok (load_ok),
      .rsp     (rsp)
   );
endmodule

`default_nettype wire

>>> sim/message_packet_segmenter_tb.sv
// ----------------------------------------------------------------------------
// message_packet_segmenter_tb
// Self-checking regression for the message packet segmenter. Content bytes
// are sent on the request channel with random gaps. A scoreboard predicts
// every header and payload word of the packet stream and checks each word
// taken from the result channel. The packet size register is changed between
// phases, including in the middle of open messages.
// ----------------------------------------------------------------------------

class packet_stream_board;
   typedef struct packed {
      logic [7:0] value;
      logic       eop;
      logic       eom;
   } stream_word_type;

   stream_word_type pending_words[$];

   logic [15:0] seg_size;
   logic [23:0] bytes_left;
   logic [15:0] payload_count;
   logic [15:0] packet_index;
   logic [21:0] held_frame;
   logic [1:0]  held_mode;
   logic [23:0] held_length;

   int unsigned errors;
   int unsigned messages;
   int unsigned packets;
   int unsigned words_checked;

   function new();
      seg_size      = msp_pkg::SEG_SIZE_RESET;
      bytes_left    = '0;
      payload_count = '0;
      packet_index  = '0;
      held_frame    = '0;
      held_mode     = '0;
      held_length   = '0;
      errors        = 0;
      messages      = 0;
      packets       = 0;
      words_checked = 0;
   endfunction

   function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) begin
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
      end
   endfunction

   function void push_word(logic [7:0] value, logic eop, logic eom);
      stream_word_type w;
      w.value = value;
      w.eop   = eop;
      w.eom   = eom;
      pending_words.push_back(w);
   endfunction

   // Notes one accepted content byte and queues the words it causes.
   function void take_byte(logic [7:0] data, logic [21:0] frame, logic [1:0] mode,
                           logic [23:0] length);
      logic [15:0] eff_size;
      logic [15:0] payload_max;
      logic        eom;
      logic        eop;
      eff_size    = (seg_size < msp_pkg::MIN_PACKET) ? msp_pkg::MIN_PACKET : seg_size;
      payload_max = eff_size - msp_pkg::HDR_BYTES;
      if (bytes_left == 24'd0) begin
         // A first byte that announces an empty message is dropped.
         if (length == 24'd0) return;
         held_frame    = frame;
         held_mode     = mode;
         held_length   = length;
         bytes_left    = length;
         payload_count = '0;
         packet_index  = '0;
         messages++;
      end
      if (payload_count == 16'd0) begin
         push_word(held_frame[7:0], 1'b0, 1'b0);
         push_word(held_frame[15:8], 1'b0, 1'b0);
         push_word({held_mode, held_frame[21:16]}, 1'b0, 1'b0);
         push_word(packet_index[7:0], 1'b0, 1'b0);
         push_word(packet_index[15:8], 1'b0, 1'b0);
         push_word(held_length[7:0], 1'b0, 1'b0);
         push_word(held_length[15:8], 1'b0, 1'b0);
         push_word(held_length[23:16], 1'b0, 1'b0);
      end
      payload_count = payload_count + 16'd1;
      bytes_left    = bytes_left - 24'd1;
      eom = (bytes_left == 24'd0);
      // A shrunken size can end the packet at once on the byte just taken.
      eop = eom || (payload_count >= payload_max);
      push_word(data, eop, eom);
      if (eop) begin
         payload_count = '0;
         packet_index  = packet_index + 16'd1;
         packets++;
      end
   endfunction

   function void check_byte(logic [7:0] value, logic eop, logic eom);
      stream_word_type want;
      if (pending_words.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("UNEXPECTED word 0x%0h (eop %0b, eom %0b)", value, eop, eom);
         end
         return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (value !== want.value) flag("out_byte", 32'(want.value), 32'(value));
      if (eop !== want.eop) flag("end_of_packet", 32'(want.eop), 32'(eop));
      if (eom !== want.eom) flag("end_of_message", 32'(want.eom), 32'(eom));
   endfunction
endclass

module message_packet_segmenter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msp_pkg::*;

   localparam logic [2:0] SIZE_ADDR = 3'(4 * REG_SEG_SIZE);

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   msp_req_if req ();
   msp_rsp_if rsp ();

   message_packet_segmenter dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   packet_stream_board board = new();

   logic        idling;
   logic [23:0] open_left;
   int unsigned items_sent;
   int unsigned size_writes;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= !idling || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         board.check_byte(rsp.out_byte, rsp.end_of_packet, rsp.end_of_message);
      end
   end

   initial begin
      #40ms;
      $display("message_packet_segmenter regression: fail");
      $finish;
   end

   task automatic send_item(input logic [7:0] data, input logic [21:0] frame,
                            input logic [1:0] mode, input logic [23:0] length);
      @(negedge clock);
      while (idling && $urandom_range(99) < 24) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid          <= 1'b1;
      req.data_byte      <= data;
      req.frame_number   <= frame;
      req.stream_mode    <= mode;
      req.message_length <= length;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.take_byte(data, frame, mode, length);
      if (open_left == 24'd0) begin
         if (length != 24'd0) begin
            open_left = length - 24'd1;
            items_sent++;
         end
      end else begin
         open_left = open_left - 24'd1;
         items_sent++;
      end
   endtask

   // A byte inside an open message: the attribute fields carry noise.
   task automatic send_inner();
      send_item(8'($urandom), 22'($urandom), 2'($urandom), 24'($urandom));
   endtask

   // Lowers valid and waits until every predicted word has been taken.
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic write_en, input logic [15:0] value,
                            output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= SIZE_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_seg_size(input logic [15:0] value);
      logic [31:0] rdata;
      csr_cycle(1'b1, value, rdata);
      board.seg_size = value;
      size_writes++;
      csr_cycle(1'b0, 16'd0, rdata);
      if (rdata[15:0] !== value) board.flag("size readback", 32'(value), 32'(rdata[15:0]));
   endtask

   task automatic send_random(input int n);
      int          k;
      int unsigned r;
      logic [23:0] length;
      k = 0;
      while (k < n) begin
         if ($urandom_range(99) < 2) drain();
         if (open_left != 24'd0) begin
            send_inner();
            k++;
         end else if ($urandom_range(99) < 10) begin
            send_item(8'($urandom), 22'($urandom), 2'($urandom), 24'd0);
         end else begin
            r = $urandom_range(99);
            if (r < 60) length = 24'($urandom_range(20, 1));
            else if (r < 90) length = 24'($urandom_range(120, 21));
            else length = 24'($urandom_range(400, 121));
            send_item(8'($urandom), 22'($urandom), 2'($urandom), length);
            k++;
         end
      end
   endtask

   initial begin
      logic [31:0] rdata;
      int          p;
      reset              = 1'b1;
      idling             = 1'b1;
      open_left          = '0;
      items_sent         = 0;
      size_writes        = 0;
      req.valid          = 1'b0;
      req.data_byte      = '0;
      req.frame_number   = '0;
      req.stream_mode    = '0;
      req.message_length = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      csr_cycle(1'b0, 16'd0, rdata);
      if (rdata[15:0] !== SEG_SIZE_RESET) begin
         board.flag("size after reset", 32'(SEG_SIZE_RESET), 32'(rdata[15:0]));
      end

      // Short message at the reset size, data extremes, zero frame and mode.
      send_item(8'h00, 22'd0, 2'd0, 24'd3);
      send_item(8'hFF, 22'h3FFFFF, 2'd3, 24'hFFFFFF);
      send_item(8'h5A, 22'h155555, 2'd1, 24'd0);
      // An empty message is dropped without a word.
      send_item(8'hA5, 22'h3FFFFF, 2'd3, 24'd0);
      drain();

      // Smallest packets: one payload byte each, then sizes under the minimum.
      set_seg_size(MIN_PACKET);
      send_item(8'hFF, 22'h3FFFFF, 2'd3, 24'd2);
      send_item(8'h00, 22'd0, 2'd0, 24'd0);
      drain();
      set_seg_size(16'd0);
      send_item(8'h81, 22'h2AAAAA, 2'd2, 24'd2);
      send_inner();
      drain();
      set_seg_size(16'd8);
      send_item(8'h7E, 22'h155555, 2'd1, 24'd1);
      drain();

      // Size changes while a message is open.
      set_seg_size(16'd20);
      send_item(8'h3C, 22'h2AAAAA, 2'd2, 24'd10);
      repeat (5) send_inner();
      drain();
      set_seg_size(16'd11);
      repeat (2) send_inner();
      drain();
      set_seg_size(16'hFFFF);
      repeat (2) send_inner();
      drain();

      for (p = 0; p < 8; p++) begin
         case (p)
            0: set_seg_size(MIN_PACKET);
            1: set_seg_size(16'hFFFF);
            2: set_seg_size(16'($urandom_range(24, 9)));
            3: begin
               set_seg_size(16'd0);
               idling = 1'b0;
            end
            4: set_seg_size(16'($urandom_range(80, 25)));
            5: set_seg_size(16'd10);
            6: set_seg_size(16'($urandom_range(300, 9)));
            default: set_seg_size(16'($urandom_range(16, 9)));
         endcase
         send_random(40);
         drain();
         idling = 1'b1;
      end

      // Close the open message, then leave one of the longest length open.
      while (open_left != 24'd0) send_inner();
      drain();
      set_seg_size(16'd13);
      send_item(8'($urandom), 22'h3FFFFF, 2'd3, 24'hFFFFFF);
      repeat (11) send_inner();
      drain();

      $display("Run covered %0d content bytes in %0d messages and %0d packets, %0d sizes.",
               items_sent, board.messages, board.packets, size_writes);
      $display("Checked %0d output words, with empty messages and mid-message size changes.",
               board.words_checked);
      if (board.errors == 0) begin
         $display("message_packet_segmenter regression: pass");
      end else begin
         $display("%0d mismatches in total.", board.errors);
         $display("message_packet_segmenter regression: fail");
      end
      $finish;
   end
endmodule
